// ===== rtl/core/nearest_reference_distance_defines.svh =====
`ifndef NEAREST_REFERENCE_DISTANCE_DEFINES_SVH
`define NEAREST_REFERENCE_DISTANCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define NRD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NRD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/nrd_pkg.sv =====
`timescale 1ns / 1ps

package nrd_pkg;

	localparam int DEF_MAX_REF     = 2048;
	localparam int DEF_MAX_QUERIES = 65536;
	localparam int DEF_COORD_BITS  = 24;

	localparam int DIST_W    = 25;
	localparam int SUM_W     = 41;
	localparam int STEP_W    = 6;
	localparam int DIV_STEPS = SUM_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_DIV  = 6'b100000
	} state_t;

endpackage

// ===== rtl/core/nearest_reference_distance.sv =====
`timescale 1ns / 1ps
`include "nearest_reference_distance_defines.svh"

// Brute-force 3D nearest neighbor over a stored reference set. A transaction is
// taken when start is high and busy is low. Clear, append and unused op codes
// finish as they are taken and give no result. A query runs one shared
// multiplier that squares one axis per cycle, then one compare per point, then a
// one-bit-per-cycle square root, and then the restoring divider when last_query
// is set. A query on an empty set skips the distance steps and gives a zero
// distance. The result appears for one cycle with done high and must be taken
// then; busy drops in the same cycle.
module nearest_reference_distance
	import nrd_pkg::*;
#(
	parameter int MAX_REF     = DEF_MAX_REF,
	parameter int MAX_QUERIES = DEF_MAX_QUERIES,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] pz,
	input  logic                         last_query,
	output logic                         done,
	output logic [DIST_W-1:0]            nearest_distance,
	output logic [DIST_W-1:0]            mean_distance,
	output logic                         batch_done,
	output logic                         no_reference
);

	localparam int IW   = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
	localparam int CW   = $clog2(MAX_REF + 1);
	localparam int QW   = $clog2(MAX_QUERIES + 1);
	localparam int MW   = COORD_BITS + 1;          // |difference|
	localparam int D2W  = 2 * COORD_BITS + 2;      // sum of three squares
	localparam int RW   = COORD_BITS + 1;          // root width
	localparam int RMW  = COORD_BITS + 3;          // sqrt remainder
	localparam int XW   = (RW > DIST_W) ? RW : DIST_W;
	localparam int QXW  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	logic [COORD_BITS-1:0] mem_x [MAX_REF];
	logic [COORD_BITS-1:0] mem_y [MAX_REF];
	logic [COORD_BITS-1:0] mem_z [MAX_REF];

	state_t                state_q;
	logic [CW-1:0]         ref_cnt_q;
	logic [CW-1:0]         idx_q;
	logic [1:0]            ax_q;
	logic [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [COORD_BITS-1:0] rx_q, ry_q, rz_q;
	logic                  last_q;
	logic                  empty_q;
	logic [D2W-1:0]        prod_q, acc_q, best_q;
	logic [D2W-1:0]        val_q;
	logic [RMW-1:0]        rem_q;
	logic [RW-1:0]         root_q;
	logic [STEP_W-1:0]     step_q;
	logic [SUM_W-1:0]      sum_q;
	logic [QW-1:0]         qcnt_q;
	logic [SUM_W-1:0]      quot_q;
	logic [QW-1:0]         dvsr_q;
	logic [QW:0]           drem_q;
	logic                  done_q, bdone_q, noref_q;
	logic [DIST_W-1:0]     dist_q, mean_q;

	logic                  accept;
	logic [IW-1:0]         rd_addr;
	logic [CW-1:0]         idx_nx;
	logic [COORD_BITS-1:0] qa, ra;
	logic signed [MW-1:0]  diff;
	logic [MW-1:0]         mag;
	logic [2*MW-1:0]       sq;
	logic [D2W-1:0]        d2;
	logic [D2W-1:0]        best_nx;
	logic [RMW-1:0]        srem_sh, strial;
	logic [XW-1:0]         root_ext;
	logic [DIST_W-1:0]     dist_w;
	logic [SUM_W:0]        sum_add;
	logic [SUM_W-1:0]      sum_upd;
	logic [QW-1:0]         qcnt_upd;
	logic [QW:0]           drem_sh;
	logic [QXW-1:0]        quot_ext;
	logic [DIST_W-1:0]     mean_w;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign idx_nx = idx_q + CW'(1);

	// point 0 is read at accept; compare fetches the next point, held through the multiplies
	assign rd_addr = (state_q == ST_CMP) ? idx_nx[IW-1:0] :
		(state_q == ST_IDLE) ? IW'(0) : idx_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (accept && op == OP_APPEND && ref_cnt_q < CW'(MAX_REF)) begin
			mem_x[ref_cnt_q[IW-1:0]] <= px;
			mem_y[ref_cnt_q[IW-1:0]] <= py;
			mem_z[ref_cnt_q[IW-1:0]] <= pz;
		end
		rx_q <= mem_x[rd_addr];
		ry_q <= mem_y[rd_addr];
		rz_q <= mem_z[rd_addr];
	end

	// shared squaring unit, one axis per cycle
	always_comb begin
		if (ax_q == 2'd0) begin
			qa = qx_q;
			ra = rx_q;
		end else if (ax_q == 2'd1) begin
			qa = qy_q;
			ra = ry_q;
		end else begin
			qa = qz_q;
			ra = rz_q;
		end
	end

	assign diff = $signed({qa[COORD_BITS-1], qa}) - $signed({ra[COORD_BITS-1], ra});
	assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
	assign sq   = mag * mag;

	assign d2      = acc_q + prod_q;
	assign best_nx = (d2 < best_q) ? d2 : best_q;

	assign srem_sh = {rem_q[RMW-3:0], val_q[D2W-1 -: 2]};
	assign strial  = {root_q, 2'b00} | RMW'(1);

	assign root_ext = XW'(root_q);
	assign dist_w   = empty_q ? '0 :
		(root_ext > XW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

	assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(dist_w);
	assign sum_upd  = (qcnt_q < QW'(MAX_QUERIES))
		? (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]) : sum_q;
	assign qcnt_upd = (qcnt_q < QW'(MAX_QUERIES)) ? qcnt_q + QW'(1) : qcnt_q;

	assign drem_sh  = {drem_q[QW-1:0], quot_q[SUM_W-1]};
	assign quot_ext = QXW'(quot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ref_cnt_q <= '0;
			sum_q     <= '0;
			qcnt_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (op == OP_CLEAR) begin
							ref_cnt_q <= '0;
						end else if (op == OP_APPEND) begin
							if (ref_cnt_q < CW'(MAX_REF))
								ref_cnt_q <= ref_cnt_q + CW'(1);
						end else if (op == OP_QUERY) begin
							state_q <= (ref_cnt_q == '0) ? ST_ACC : ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (ax_q == 2'd2)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (idx_nx == ref_cnt_q)
						state_q <= ST_SQRT;
					else
						state_q <= ST_MUL;
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(RW - 1))
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q  <= last_q ? '0 : sum_upd;
					qcnt_q <= last_q ? '0 : qcnt_upd;
					if (last_q) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qx_q    <= px;
				qy_q    <= py;
				qz_q    <= pz;
				last_q  <= last_query;
				empty_q <= (ref_cnt_q == '0);
				idx_q   <= '0;
				ax_q    <= 2'd0;
				best_q  <= '1;
			end
			ST_MUL: begin
				prod_q <= D2W'(sq);
				if (ax_q == 2'd0)
					acc_q <= '0;
				else if (ax_q == 2'd1)
					acc_q <= prod_q;
				else
					acc_q <= d2;
				ax_q <= ax_q + 2'd1;
			end
			ST_CMP: begin
				best_q <= best_nx;
				idx_q  <= idx_nx;
				ax_q   <= 2'd0;
				val_q  <= best_nx;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ST_SQRT: begin
				val_q  <= val_q << 2;
				step_q <= step_q + STEP_W'(1);
				if (srem_sh >= strial) begin
					rem_q  <= srem_sh - strial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= srem_sh;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			ST_ACC: begin
				dist_q  <= dist_w;
				noref_q <= empty_q;
				bdone_q <= last_q;
				mean_q  <= '0;
				quot_q  <= sum_upd;
				dvsr_q  <= qcnt_upd;
				drem_q  <= '0;
				step_q  <= '0;
			end
			ST_DIV: begin
				step_q <= step_q + STEP_W'(1);
				if (drem_sh >= {1'b0, dvsr_q}) begin
					drem_q <= drem_sh - {1'b0, dvsr_q};
					quot_q <= {quot_q[SUM_W-2:0], 1'b1};
				end else begin
					drem_q <= drem_sh;
					quot_q <= {quot_q[SUM_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// quotient is final after the last step; saturate on the way out
	assign mean_w = (dvsr_q == '0) ? '0 :
		(quot_ext > QXW'(DIST_MAX)) ? DIST_MAX : quot_ext[DIST_W-1:0];

	assign done             = done_q;
	assign nearest_distance = dist_q;
	assign mean_distance    = bdone_q ? mean_w : mean_q;
	assign batch_done       = bdone_q;
	assign no_reference     = noref_q;

	`NRD_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a query in flight")
	`NRD_ASSERT_IMP(a_noref_zero, done && no_reference, nearest_distance == '0,
		"empty set gave nonzero distance")
	`NRD_ASSERT_IMP(a_mean_zero, done && !batch_done, mean_distance == '0,
		"mean nonzero outside a batch close")
	`NRD_ASSERT_IMP(a_ref_bound, 1'b1, ref_cnt_q <= CW'(MAX_REF), "reference count overrun")
	`NRD_ASSERT_NXT(a_idle_after_done, done, !busy || $past(start),
		"busy held past the result")

endmodule
